// ----- rtl/core/load_cell_average_tare_scale_unit_defines.svh -----
// Assertion macros shared by the load-cell average, tare and scale RTL.
`ifndef LOAD_CELL_AVERAGE_TARE_SCALE_UNIT_DEFINES_SVH
`define LOAD_CELL_AVERAGE_TARE_SCALE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle property, disabled while reset is high.
`define LCATS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define LCATS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCATS_ASSERT(lbl, clk, rst, prop, msg)
`define LCATS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/core/lcats_pkg.sv -----
// Shared types and constants of the load-cell average, tare and scale unit.
package lcats_pkg;

   localparam int WEIGHT_BITS           = 40;
   localparam int SCALE_BITS            = 32;
   localparam int CSR_DATA_BITS         = 32;
   localparam int CSR_INDEX_BITS        = 2;
   localparam int SAMPLE_COUNT_REG_BITS = 16;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_POS_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_NEG_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   localparam logic [SCALE_BITS-1:0] SCALE_RECIP_RESET = SCALE_BITS'(65536);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SAMPLE_COUNT = 2'd0,
      CSR_SCALE_RECIP  = 2'd1,
      CSR_TARE_MODE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_SCALE,
      ST_HOLD
   } state_type;

endpackage

// ----- rtl/core/lcats_if.sv -----
// Valid/ready channel interfaces for samples, results and register writes.
interface lcats_req_if #(parameter int SAMPLE_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] raw_word;

   modport source (output valid, output raw_word, input ready);
   modport sink   (input valid, input raw_word, output ready);
endinterface

interface lcats_rsp_if #(parameter int SAMPLE_BITS = 24);
   import lcats_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [WEIGHT_BITS-1:0] weight_q16;
   logic        [SAMPLE_BITS-1:0] average_code;
   logic                          tared;

   modport source (output valid, output weight_q16, output average_code, output tared,
                   input ready);
   modport sink   (input valid, input weight_q16, input average_code, input tared,
                   output ready);
endinterface

interface lcats_csr_if;
   import lcats_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/lcats_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module lcats_divider #(
   parameter int DIVIDEND_BITS = 40,
   parameter int DIVISOR_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  den_ff, den_in;
   logic [DIVISOR_BITS:0]    trial;
   logic [DIVISOR_BITS:0]    diff;

   // The dividend shifts out of the top of quo_ff while quotient bits enter at the bottom.
   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_BITS]) begin
            rem_in = diff[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/core/lcats_scaler.sv -----
// Bit-serial shift-add multiplier that scales the tare difference, with saturation.
module lcats_scaler
   import lcats_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic        [SAMPLE_BITS-1:0] average,
   input  logic        [SAMPLE_BITS-1:0] offset,
   input  logic signed [SCALE_BITS-1:0]  scale,
   output logic                          done,
   output logic signed [WEIGHT_BITS-1:0] weight
);
   localparam int PROD_BITS = SAMPLE_BITS + SCALE_BITS;
   localparam int EXT_BITS  = (PROD_BITS > WEIGHT_BITS + 1) ? PROD_BITS : WEIGHT_BITS + 1;
   localparam int CNT_BITS  = $clog2(SCALE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   sat_ff, sat_in;
   logic                   done_ff, done_in;
   logic                   neg_ff, neg_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] dmag_ff, dmag_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;

   logic                   dneg;
   logic [SAMPLE_BITS-1:0] dmag;
   logic [SCALE_BITS-1:0]  scale_u;
   logic [SCALE_BITS-1:0]  smag;
   logic [SAMPLE_BITS:0]   partial;
   logic [EXT_BITS-1:0]    prod_ext;
   logic                   over_pos;
   logic                   over_neg;
   logic [WEIGHT_BITS-1:0] mag;

   assign dneg    = average < offset;
   assign dmag    = dneg ? (offset - average) : (average - offset);
   assign scale_u = scale;
   assign smag    = scale_u[SCALE_BITS-1] ? (~scale_u + 1'b1) : scale_u;

   // One multiplier bit per cycle: add the difference into the upper half, then shift right.
   assign partial = prod_ff[0]
                  ? ({1'b0, prod_ff[PROD_BITS-1:SCALE_BITS]} + {1'b0, dmag_ff})
                  : {1'b0, prod_ff[PROD_BITS-1:SCALE_BITS]};

   assign prod_ext = EXT_BITS'(prod_ff);
   assign over_pos = |prod_ext[EXT_BITS-1:WEIGHT_BITS-1];
   assign over_neg = (|prod_ext[EXT_BITS-1:WEIGHT_BITS])
                   || (prod_ext[WEIGHT_BITS-1] && (|prod_ext[WEIGHT_BITS-2:0]));
   assign mag      = prod_ext[WEIGHT_BITS-1:0];

   always_comb begin
      busy_in   = busy_ff;
      sat_in    = 1'b0;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      dmag_in   = dmag_ff;
      prod_in   = prod_ff;
      weight_in = weight_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dneg ^ scale_u[SCALE_BITS-1];
         cnt_in  = CNT_BITS'(SCALE_BITS);
         dmag_in = dmag;
         prod_in = {{SAMPLE_BITS{1'b0}}, smag};
      end else if (busy_ff) begin
         prod_in = {partial, prod_ff[SCALE_BITS-1:1]};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            sat_in  = 1'b1;
         end
      end else if (sat_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            weight_in = over_neg ? WEIGHT_NEG_MIN : (~mag + 1'b1);
         end else begin
            weight_in = over_pos ? WEIGHT_POS_MAX : mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sat_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sat_ff  <= sat_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff    <= neg_in;
      dmag_ff   <= dmag_in;
      prod_ff   <= prod_in;
      weight_ff <= weight_in;
   end

   assign done   = done_ff;
   assign weight = weight_ff;

endmodule

// ----- rtl/core/load_cell_average_tare_scale_unit.sv -----
// Top level of the load-cell average, tare and scale unit.
//
// Usage: raw converter words arrive as beats on req_ch. The top bit of each word is
// flipped to an offset-binary code, and a code of zero (converter timeout) is
// dropped. Accepted codes are summed until sample_count of them have been seen
// (a count of zero acts as one); the sum is then divided by sample_count.
// In tare mode the average becomes the stored offset and the result beat on
// rsp_ch carries tared = 1 and a zero weight. In weigh mode the beat carries
// (average - offset) * scale_recip in Q16.16, saturated to 40 bits.
// Registers are written on csr_ch, which is always ready; write them only
// while no run is being computed.
// Throughput: a sample that does not end a run takes one cycle. A sample that
// ends a run starts a bit-serial divide, then in weigh mode a bit-serial
// multiply and a saturation step; the result beat is then loaded into the
// output register and shown on rsp_ch.
// req_ch is held off while a run is being divided or scaled, and while the
// finished result waits to enter the output register.
// A result waiting in the output register does not stop new samples; only a
// finished computation waits for the output register to drain when rsp_ch stalls.
// Reset clears the run sum, the count, the tare offset and the registers
// to their defaults (count 1, scale 1.0, weigh mode).
`include "load_cell_average_tare_scale_unit_defines.svh"

module load_cell_average_tare_scale_unit #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   lcats_req_if.sink   req_ch,
   lcats_rsp_if.source rsp_ch,
   lcats_csr_if.sink   csr_ch
);
   import lcats_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Configuration registers.
   logic [COUNT_BITS-1:0]        sample_count_ff, sample_count_in;
   logic signed [SCALE_BITS-1:0] scale_ff, scale_in;
   logic                         tare_mode_ff, tare_mode_in;

   // Run state.
   state_type              state_ff, state_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [SAMPLE_BITS-1:0] tare_ff, tare_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [SAMPLE_BITS-1:0]        avg_ff, avg_in;
   logic                          tared_ff, tared_in;

   logic [SAMPLE_BITS-1:0] code;
   logic                   take;
   logic [COUNT_BITS-1:0]  count_next;
   logic [COUNT_BITS-1:0]  divisor;
   logic                   complete;
   logic [SUM_BITS-1:0]    sum_next;
   logic                   csr_write;

   logic                          req_ready;
   logic                          div_start;
   logic                          mul_start;
   logic                          load_rsp;
   logic                          div_done;
   logic [SUM_BITS-1:0]           quotient;
   logic [SAMPLE_BITS-1:0]        average;
   logic                          mul_done;
   logic signed [WEIGHT_BITS-1:0] mul_weight;

   assign code       = req_ch.raw_word ^ SIGN_FLIP;
   assign take       = req_ch.valid && req_ready && (code != '0);
   assign count_next = count_ff + 1'b1;
   assign divisor    = (sample_count_ff == '0) ? COUNT_BITS'(1) : sample_count_ff;
   // A run ends once the count reaches the divisor; a lowered count ends it at once.
   assign complete   = !((count_next < divisor) && (count_next != '0));
   assign sum_next   = sum_ff + SUM_BITS'(code);
   assign average    = quotient[SAMPLE_BITS-1:0];
   assign csr_write  = csr_ch.valid && csr_ch.ready;

   lcats_divider #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_next),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   lcats_scaler #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scaler (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .average (average),
      .offset  (tare_ff),
      .scale   (scale_ff),
      .done    (mul_done),
      .weight  (mul_weight)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (take && complete) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = tare_mode_ff ? ST_HOLD : ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (mul_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = ST_ACCUM;
            end
         end
         default: state_in = ST_ACCUM;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      mul_start = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready = 1'b1;
            div_start = take && complete;
         end
         ST_DIVIDE: mul_start = div_done && !tare_mode_ff;
         ST_SCALE:  mul_start = 1'b0;
         ST_HOLD:   load_rsp  = !rsp_valid_ff || rsp_ch.ready;
         default:   req_ready = 1'b0;
      endcase
   end

   // Accumulator, tare offset and output register.
   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      tare_in      = tare_ff;
      weight_in    = weight_ff;
      avg_in       = avg_ff;
      tared_in     = tared_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (take) begin
         if (complete) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
         end
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         avg_in       = average;
         tared_in     = tare_mode_ff;
         weight_in    = tare_mode_ff ? '0 : mul_weight;
         if (tare_mode_ff) begin
            tare_in = average;
         end
      end
   end

   // Register writes; an index past the register list is ignored.
   always_comb begin
      sample_count_in = sample_count_ff;
      scale_in        = scale_ff;
      tare_mode_in    = tare_mode_ff;
      if (csr_write) begin
         unique case (csr_ch.index)
            CSR_SAMPLE_COUNT: sample_count_in =
               COUNT_BITS'(csr_ch.data[SAMPLE_COUNT_REG_BITS-1:0]);
            CSR_SCALE_RECIP:  scale_in        = csr_ch.data[SCALE_BITS-1:0];
            CSR_TARE_MODE:    tare_mode_in    = csr_ch.data[0];
            default:          tare_mode_in    = tare_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_ACCUM;
         sum_ff          <= '0;
         count_ff        <= '0;
         tare_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         sample_count_ff <= COUNT_BITS'(1);
         scale_ff        <= SCALE_RECIP_RESET;
         tare_mode_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sum_ff          <= sum_in;
         count_ff        <= count_in;
         tare_ff         <= tare_in;
         rsp_valid_ff    <= rsp_valid_in;
         sample_count_ff <= sample_count_in;
         scale_ff        <= scale_in;
         tare_mode_ff    <= tare_mode_in;
      end
      weight_ff <= weight_in;
      avg_ff    <= avg_in;
      tared_ff  <= tared_in;
   end

   assign req_ch.ready        = req_ready;
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.weight_q16   = weight_ff;
   assign rsp_ch.average_code = avg_ff;
   assign rsp_ch.tared        = tared_ff;

   // The run sum is cleared when a run ends and stays clear until sampling resumes.
   `LCATS_ASSERT(a_sum_clear_while_busy, clock, reset, (state_ff != ST_ACCUM) |-> (sum_ff == '0), "run sum not clear while busy")
   // Ending a run clears the count and moves to the divide.
   `LCATS_ASSERT_NEXT(a_run_end_clears, clock, reset, div_start, (count_ff == '0) && (state_ff == ST_DIVIDE), "run end did not clear count")
   // Loading the output register raises valid and returns to sampling.
   `LCATS_ASSERT_NEXT(a_load_shows_result, clock, reset, load_rsp, rsp_valid_ff && (state_ff == ST_ACCUM), "result load did not show a beat")

endmodule
